### rtl/core/lep_pkg.sv
package lep_pkg;

    localparam int POOL_SIZE_DEF = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int LIFE_W    = 24;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd2;

    localparam logic [CFG_W-1:0] INITIAL_RST = 7'd64;
    localparam logic [CFG_W-1:0] GROWTH_RST  = 7'd0;
    localparam logic [CFG_W-1:0] LIMIT_RST   = 7'd64;

    localparam logic OP_SPAWN = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] entry_limit;
        logic [CFG_W-1:0] growth_step;
        logic [CFG_W-1:0] initial_entries;
    } cfg_t;

    typedef struct packed {
        logic              operation;
        logic [LIFE_W-1:0] dt;
        logic [LIFE_W-1:0] life;
    } item_t;

    // Packed with the slot in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] active_count;
        logic [COUNT_W-1:0] expired_count;
        logic               reused;
        logic               spawn_ok;
        logic [SLOT_W-1:0]  slot;
    } res_t;

endpackage

### rtl/core/lifetime_entry_pool_top.sv
// Pool of timed entries kept on a LIFO free list and an active list in two
// on-chip memories (links and 25-bit remaining lives), driven by a small
// sequencer around one subtractor. A spawn takes an entry from the free list,
// or, when that is empty, may first grow the pool by growth_step entries, or
// else reuses the entry at the head of the active list; failing that, it fails.
// A tick walks the active list, and each step waits on the registered memory
// read. After reset and after every write of a defined register the pool is
// rebuilt by a sweep over min(initial_entries, POOL_SIZE) entries, during which
// no item is taken. Results pass through an output register, so a new item is
// taken while a result waits.
module lifetime_entry_pool_top import lep_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // life [23:0], dt [47:24]
    input  logic                 s_tuser,   // operation [0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // slot [5:0], spawn_ok [6], reused [7],
                                            // expired_count [14:8], active_count [21:15]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;
    logic  rebuild;
    logic  res_valid, res_ready;
    res_t  res;
    item_t in_item;

    assign cfg_ready = 1'b1;
    assign rebuild   = cfg_valid && (cfg_index == REG_INITIAL || cfg_index == REG_GROWTH ||
                                     cfg_index == REG_LIMIT);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_INITIAL: cfg_next.initial_entries = cfg_data;
                REG_GROWTH:  cfg_next.growth_step     = cfg_data;
                REG_LIMIT:   cfg_next.entry_limit     = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    assign in_item = '{operation: s_tuser, dt: s_tdata[47:24], life: s_tdata[23:0]};

    lep_core #(
        .POOL_SIZE (POOL_SIZE)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rebuild   (rebuild),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The output register frees the core as soon as the result is handed over.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '{entry_limit: LIMIT_RST, growth_step: GROWTH_RST,
                               initial_entries: INITIAL_RST};
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule

### rtl/core/lep_core.sv
module lep_core import lep_pkg::*; #(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  rebuild,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int SUM_W  = CFG_W + 1;
    localparam int MLIFE_W = LIFE_W + 1;

    typedef struct packed {
        logic             nil;
        logic [IDX_W-1:0] idx;
    } ptr_t;

    localparam ptr_t NIL_PTR = '{nil: 1'b1, idx: '0};

    typedef enum logic [11:0] {
        S_INIT   = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_GROW   = 12'b000000000100,
        S_SP_RD  = 12'b000000001000,
        S_SP_WR  = 12'b000000010000,
        S_RU_RD  = 12'b000000100000,
        S_RU_WR1 = 12'b000001000000,
        S_RU_WR2 = 12'b000010000000,
        S_TK_RD  = 12'b000100000000,
        S_TK_EV  = 12'b001000000000,
        S_TK_FR  = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    state_t            state_reg, state_next;
    ptr_t              free_head_reg, free_head_next;
    ptr_t              act_head_reg, act_head_next;
    ptr_t              act_tail_reg, act_tail_next;
    ptr_t              cur_reg, cur_next;
    ptr_t              prev_reg, prev_next;
    ptr_t              nxt_reg, nxt_next;
    logic [CNT_W-1:0]  alloc_reg, alloc_next;
    logic [CNT_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  freed_reg, freed_next;
    item_t             item_reg, item_next;
    res_t              res_reg, res_next;

    // Link and life memories, one write and one registered read each.
    ptr_t               link_mem [POOL_SIZE];
    logic [MLIFE_W-1:0] life_mem [POOL_SIZE];
    ptr_t               link_rd_reg;
    logic [MLIFE_W-1:0] life_rd_reg;

    logic               link_we, life_we, rd_en;
    logic [IDX_W-1:0]   link_wa, life_wa, rd_a;
    ptr_t               link_wd;
    logic [MLIFE_W-1:0] life_wd;

    logic [CNT_W-1:0]   n_init, lim, cnt_inc, sweep_end;
    logic [SUM_W-1:0]   grow_sum;
    logic               grow_ok;
    ptr_t               sweep_link;
    logic [MLIFE_W:0]   diff;
    logic               borrow;

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (life_we) begin
            life_mem[life_wa] <= life_wd;
        end
        if (rd_en) begin
            link_rd_reg <= link_mem[rd_a];
            life_rd_reg <= life_mem[rd_a];
        end
    end

    assign n_init = (cfg.initial_entries > CFG_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                               : cfg.initial_entries[CNT_W-1:0];
    assign lim    = (cfg.entry_limit > CFG_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                           : cfg.entry_limit[CNT_W-1:0];
    assign grow_sum = SUM_W'(alloc_reg) + SUM_W'(cfg.growth_step);
    assign grow_ok  = (cfg.growth_step != '0) && (grow_sum <= SUM_W'(lim));

    // Chain builder shared by the rebuild sweep and the growth sweep.
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign sweep_end = state_reg == S_INIT ? n_init : end_reg;
    always_comb begin
        sweep_link = NIL_PTR;
        if (cnt_inc < sweep_end) begin
            sweep_link = '{nil: 1'b0, idx: cnt_inc[IDX_W-1:0]};
        end
    end

    // The subtract unit: new life and the expiry decision in one step.
    assign diff   = {1'b0, life_rd_reg} - {2'b00, item_reg.dt};
    assign borrow = diff[MLIFE_W];

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        act_head_next  = act_head_reg;
        act_tail_next  = act_tail_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        alloc_next     = alloc_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        freed_next     = freed_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        link_we        = 1'b0;
        link_wa        = cnt_reg[IDX_W-1:0];
        link_wd        = sweep_link;
        life_we        = 1'b0;
        life_wa        = cur_reg.idx;
        life_wd        = {1'b0, item_reg.life};
        rd_en          = 1'b0;
        rd_a           = cur_reg.idx;

        unique case (state_reg)
            S_INIT: begin
                free_head_next = (n_init != '0) ? ptr_t'{nil: 1'b0, idx: '0} : NIL_PTR;
                act_head_next  = NIL_PTR;
                act_tail_next  = NIL_PTR;
                alloc_next     = n_init;
                num_next       = '0;
                if (cnt_reg < n_init) begin
                    link_we  = 1'b1;
                    cnt_next = cnt_inc;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    res_next  = '{slot: '0, spawn_ok: 1'b0, reused: 1'b0,
                                  expired_count: '0, active_count: COUNT_W'(num_reg)};
                    if (in_item.operation == OP_TICK) begin
                        cur_next   = act_head_reg;
                        prev_next  = NIL_PTR;
                        cnt_next   = '0;
                        freed_next = '0;
                        state_next = S_TK_RD;
                    end else if (cfg.entry_limit == '0) begin
                        state_next = S_DONE;
                    end else if (!free_head_reg.nil) begin
                        state_next = S_SP_RD;
                    end else if (grow_ok) begin
                        cnt_next   = alloc_reg;
                        end_next   = grow_sum[CNT_W-1:0];
                        state_next = S_GROW;
                    end else if (!act_head_reg.nil) begin
                        state_next = S_RU_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_GROW: begin
                link_we  = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc == end_reg) begin
                    free_head_next = '{nil: 1'b0, idx: alloc_reg[IDX_W-1:0]};
                    alloc_next     = end_reg;
                    state_next     = S_SP_RD;
                end
            end
            S_SP_RD: begin
                rd_en      = 1'b1;
                rd_a       = free_head_reg.idx;
                cur_next   = free_head_reg;
                state_next = S_SP_WR;
            end
            S_SP_WR: begin
                free_head_next = link_rd_reg;
                link_we        = 1'b1;
                link_wa        = cur_reg.idx;
                link_wd        = act_head_reg;
                life_we        = 1'b1;
                if (act_head_reg.nil) begin
                    act_tail_next = cur_reg;
                end
                act_head_next = cur_reg;
                num_next      = num_reg + CNT_W'(1);
                res_next      = '{slot: SLOT_W'(cur_reg.idx), spawn_ok: 1'b1, reused: 1'b0,
                                  expired_count: '0,
                                  active_count: COUNT_W'(num_reg + CNT_W'(1))};
                state_next    = S_DONE;
            end
            S_RU_RD: begin
                rd_en      = 1'b1;
                rd_a       = act_head_reg.idx;
                cur_next   = act_head_reg;
                state_next = S_RU_WR1;
            end
            S_RU_WR1: begin
                // The head entry moves to the tail; a single entry stays where it is.
                if (!act_tail_reg.nil && act_tail_reg != cur_reg) begin
                    link_we = 1'b1;
                    link_wa = act_tail_reg.idx;
                    link_wd = cur_reg;
                end
                act_tail_next = cur_reg;
                if (act_tail_reg == cur_reg || link_rd_reg.nil) begin
                    act_head_next = cur_reg;
                end else begin
                    act_head_next = link_rd_reg;
                end
                state_next = S_RU_WR2;
            end
            S_RU_WR2: begin
                link_we    = 1'b1;
                link_wa    = cur_reg.idx;
                link_wd    = NIL_PTR;
                life_we    = 1'b1;
                res_next   = '{slot: SLOT_W'(cur_reg.idx), spawn_ok: 1'b1, reused: 1'b1,
                               expired_count: '0, active_count: COUNT_W'(num_reg)};
                state_next = S_DONE;
            end
            S_TK_RD: begin
                if (cur_reg.nil || cnt_reg == CNT_W'(POOL_SIZE)) begin
                    res_next   = '{slot: '0, spawn_ok: 1'b0, reused: 1'b0,
                                   expired_count: COUNT_W'(freed_reg),
                                   active_count: COUNT_W'(num_reg)};
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_TK_EV;
                end
            end
            S_TK_EV: begin
                life_we = 1'b1;
                life_wd = diff[MLIFE_W-1:0];
                if (borrow) begin
                    // Unlink the expired entry from its predecessor.
                    if (prev_reg.nil) begin
                        act_head_next = link_rd_reg;
                    end else begin
                        link_we = 1'b1;
                        link_wa = prev_reg.idx;
                        link_wd = link_rd_reg;
                    end
                    if (cur_reg == act_tail_reg) begin
                        act_tail_next = prev_reg;
                    end
                    nxt_next   = link_rd_reg;
                    state_next = S_TK_FR;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd_reg;
                    cnt_next   = cnt_inc;
                    state_next = S_TK_RD;
                end
            end
            S_TK_FR: begin
                link_we        = 1'b1;
                link_wa        = cur_reg.idx;
                link_wd        = free_head_reg;
                free_head_next = cur_reg;
                if (num_reg != '0) begin
                    num_next = num_reg - CNT_W'(1);
                end
                freed_next = freed_reg + CNT_W'(1);
                cur_next   = nxt_reg;
                cnt_next   = cnt_inc;
                state_next = S_TK_RD;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
                cnt_next   = '0;
            end
        endcase

        if (rebuild) begin
            state_next = S_INIT;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            free_head_reg <= NIL_PTR;
            act_head_reg  <= NIL_PTR;
            act_tail_reg  <= NIL_PTR;
            alloc_reg     <= '0;
            num_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            free_head_reg <= free_head_next;
            act_head_reg  <= act_head_next;
            act_tail_reg  <= act_tail_next;
            alloc_reg     <= alloc_next;
            num_reg       <= num_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        nxt_reg   <= nxt_next;
        end_reg   <= end_next;
        freed_reg <= freed_next;
        item_reg  <= item_next;
        res_reg   <= res_next;
    end

endmodule
